@@ rtl/core/hac_pkg.sv @@
// ----------------------------------------------------------------------------
// hac_pkg
// Shared types, constants and the arctangent table of the angle converter.
// ----------------------------------------------------------------------------
package hac_pkg;

	localparam int COORD_W = 16;
	localparam int ANGLE_W = 16;
	localparam int CASE_W  = 2;

	localparam int COORD_FRAC_BITS_DEF = 14;
	localparam int ANGLE_BITS_DEF      = 16;
	localparam int CORDIC_STEPS_DEF    = 16;

	// radicand and root widths of the floor square roots
	localparam int RAD_W  = 62;
	localparam int ROOT_W = RAD_W / 2;
	// vector width before and inside the CORDIC
	localparam int VEC_W  = 32;
	localparam int CV_W   = 34;
	localparam int TURN_W = 32;

	localparam int QUEUE_DEPTH = 2;

	// 2^32 units per turn
	localparam logic [TURN_W-1:0] TURN_QUARTER  = 32'h4000_0000;
	localparam logic [TURN_W-1:0] TURN_HALF     = 32'h8000_0000;
	localparam logic [TURN_W-1:0] TURN_3QUARTER = 32'hC000_0000;

	typedef enum logic [CASE_W-1:0] {
		CASE_GENERAL = 2'd0,
		CASE_Z_AXIS  = 2'd1,
		CASE_ORIGIN  = 2'd2
	} case_t;

	// one classified request between front and back
	typedef struct packed {
		logic [RAD_W-1:0]        rad_w;
		logic [RAD_W-1:0]        rad_r;
		logic signed [VEC_W-1:0] vx_w;
		logic signed [VEC_W-1:0] vx_z;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		case_t                   cc;
		logic                    ovr_half;
	} job_t;

	// atan(2^-i), 2^32 units per turn
	function automatic logic [TURN_W-1:0] atan_val(input int i);
		logic [TURN_W-1:0] v;
		case (i)
			0:  v = 32'h2000_0000;
			1:  v = 32'h12E4_051E;
			2:  v = 32'h09FB_385B;
			3:  v = 32'h0511_11D4;
			4:  v = 32'h028B_0D43;
			5:  v = 32'h0145_D7E1;
			6:  v = 32'h00A2_F61E;
			7:  v = 32'h0051_7C55;
			8:  v = 32'h0028_BE53;
			9:  v = 32'h0014_5F2F;
			10: v = 32'h000A_2F98;
			11: v = 32'h0005_17CC;
			12: v = 32'h0002_8BE6;
			13: v = 32'h0001_45F3;
			14: v = 32'h0000_A2FA;
			15: v = 32'h0000_517D;
			16: v = 32'h0000_28BE;
			17: v = 32'h0000_145F;
			18: v = 32'h0000_0A30;
			19: v = 32'h0000_0518;
			20: v = 32'h0000_028C;
			21: v = 32'h0000_0146;
			22: v = 32'h0000_00A3;
			23: v = 32'h0000_0051;
			24: v = 32'h0000_0029;
			25: v = 32'h0000_0014;
			26: v = 32'h0000_000A;
			27: v = 32'h0000_0005;
			28: v = 32'h0000_0003;
			29: v = 32'h0000_0001;
			30: v = 32'h0000_0001;
			default: v = 32'h0000_0000;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/core/hac_if.sv @@
// ----------------------------------------------------------------------------
// hac_if
// Valid/ready channels of the angle converter: points in, angles out.
// ----------------------------------------------------------------------------
interface hac_pt_if;
	logic valid;
	logic ready;
	logic signed [hac_pkg::COORD_W-1:0] x_coord;
	logic signed [hac_pkg::COORD_W-1:0] y_coord;
	logic signed [hac_pkg::COORD_W-1:0] z_coord;
	logic signed [hac_pkg::COORD_W-1:0] w_coord;

	modport source (output valid, x_coord, y_coord, z_coord, w_coord, input ready);
	modport sink   (input valid, x_coord, y_coord, z_coord, w_coord, output ready);
endinterface

interface hac_ang_if;
	logic valid;
	logic ready;
	logic [hac_pkg::ANGLE_W-1:0] polar_w;
	logic [hac_pkg::ANGLE_W-1:0] polar_z;
	logic [hac_pkg::ANGLE_W-1:0] azimuth;
	logic [hac_pkg::CASE_W-1:0]  case_code;

	modport source (output valid, polar_w, polar_z, azimuth, case_code, input ready);
	modport sink   (input valid, polar_w, polar_z, azimuth, case_code, output ready);
endinterface

@@ rtl/core/hac_front.sv @@
// ----------------------------------------------------------------------------
// hac_front
// Saturates w, classifies the point and forms the square-root radicands.
// ----------------------------------------------------------------------------
module hac_front #(
	parameter int COORD_FRAC_BITS = hac_pkg::COORD_FRAC_BITS_DEF
) (
	hac_pt_if.sink          pt,
	output hac_pkg::job_t   job,
	output logic            job_valid,
	input  logic            job_ready
);

	localparam int K = 30 - COORD_FRAC_BITS;
	localparam logic signed [31:0] ONE = 32'sd1 <<< COORD_FRAC_BITS;
	localparam logic [hac_pkg::RAD_W-1:0] ONE_SQ =
		hac_pkg::RAD_W'(1) << (2 * COORD_FRAC_BITS);

	logic signed [31:0] w_ext;
	logic signed [31:0] w_sat;
	logic signed [16:0] w_n;
	logic signed [33:0] ww;
	logic signed [31:0] xx;
	logic signed [31:0] yy;
	logic [31:0]        rr;
	logic [hac_pkg::RAD_W-1:0] d;

	assign job_valid = pt.valid;
	assign pt.ready  = job_ready;

	always_comb begin
		w_ext = 32'(pt.w_coord);
		if (w_ext > ONE) begin
			w_sat = ONE;
		end else if (w_ext < -ONE) begin
			w_sat = -ONE;
		end else begin
			w_sat = w_ext;
		end
		w_n = w_sat[16:0];
		ww  = w_n * w_n;
		d   = ONE_SQ - hac_pkg::RAD_W'($unsigned(ww));

		xx = pt.x_coord * pt.x_coord;
		yy = pt.y_coord * pt.y_coord;
		rr = $unsigned(xx) + $unsigned(yy);

		job.rad_w = d << (2 * K);
		job.rad_r = {rr, 30'b0};
		job.vx_w  = 32'(w_n) <<< K;
		job.vx_z  = 32'(pt.z_coord) <<< 15;
		job.x     = pt.x_coord;
		job.y     = pt.y_coord;

		// degenerate points: origin of xyz, or on the z axis
		if (pt.x_coord == '0 && pt.y_coord == '0 && pt.z_coord == '0) begin
			job.cc       = hac_pkg::CASE_ORIGIN;
			job.ovr_half = !(pt.w_coord > 0);
		end else if (pt.x_coord == '0 && pt.y_coord == '0) begin
			job.cc       = hac_pkg::CASE_Z_AXIS;
			job.ovr_half = !(pt.z_coord > 0);
		end else begin
			job.cc       = hac_pkg::CASE_GENERAL;
			job.ovr_half = 1'b0;
		end
	end

endmodule

@@ rtl/core/hac_queue.sv @@
// ----------------------------------------------------------------------------
// hac_queue
// Short request queue between front and back.
// ----------------------------------------------------------------------------
module hac_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  hac_pkg::job_t wr_data,
	input  logic          wr_valid,
	output logic          wr_ready,
	output hac_pkg::job_t rd_data,
	output logic          rd_valid,
	input  logic          rd_ready
);

	localparam int DEPTH = hac_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	hac_pkg::job_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             wr;
	logic             rd;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr_ready = cnt_q != CNT_W'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign wr       = wr_valid && wr_ready;
	assign rd       = rd_valid && rd_ready;
	assign rd_data  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= ptr_inc(wptr_q);
			end
			if (rd) begin
				rptr_q <= ptr_inc(rptr_q);
			end
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	a_cnt_push: assert property (@(posedge clk) disable iff (!arst_n)
		wr && !rd |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count missed a push");

endmodule

@@ rtl/core/hac_sqrt_pipe.sv @@
// ----------------------------------------------------------------------------
// hac_sqrt_pipe
// Pipelined floor square root, one root bit per stage.
// ----------------------------------------------------------------------------
module hac_sqrt_pipe (
	input  logic                       clk,
	input  logic                       en,
	input  logic [hac_pkg::RAD_W-1:0]  rad,
	output logic [hac_pkg::ROOT_W-1:0] root
);

	localparam int RW = hac_pkg::RAD_W;
	localparam int QW = hac_pkg::ROOT_W;

	logic [RW-1:0] rad_s  [QW];
	logic [QW+1:0] rem_s  [QW];
	logic [QW-1:0] root_s [QW+1];

	logic [QW+1:0] rem2  [QW];
	logic [QW+1:0] trial [QW];
	logic [QW+1:0] nrem  [QW];
	logic [QW-1:0] nroot [QW];

	always_comb begin
		for (int j = 0; j < QW; j++) begin
			rem2[j]  = {rem_s[j][QW-1:0], rad_s[j][RW-1 -: 2]};
			trial[j] = {root_s[j], 2'b01};
			if (rem2[j] >= trial[j]) begin
				nrem[j]  = rem2[j] - trial[j];
				nroot[j] = {root_s[j][QW-2:0], 1'b1};
			end else begin
				nrem[j]  = rem2[j];
				nroot[j] = {root_s[j][QW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s[0]  <= rad;
			rem_s[0]  <= '0;
			root_s[0] <= '0;
			for (int j = 0; j < QW - 1; j++) begin
				rad_s[j+1] <= rad_s[j] << 2;
				rem_s[j+1] <= nrem[j];
			end
			for (int j = 0; j < QW; j++) begin
				root_s[j+1] <= nroot[j];
			end
		end
	end

	assign root = root_s[QW];

endmodule

@@ rtl/core/hac_cordic_pipe.sv @@
// ----------------------------------------------------------------------------
// hac_cordic_pipe
// Vectoring CORDIC, one micro-rotation per stage; yields the angle sum.
// ----------------------------------------------------------------------------
module hac_cordic_pipe #(
	parameter int CORDIC_STEPS = hac_pkg::CORDIC_STEPS_DEF
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [hac_pkg::CV_W-1:0]   vx,
	input  logic signed [hac_pkg::CV_W-1:0]   vy,
	output logic [hac_pkg::TURN_W-1:0]        acc
);

	localparam int CW = hac_pkg::CV_W;
	localparam int TW = hac_pkg::TURN_W;

	logic signed [CW-1:0] vx_s  [CORDIC_STEPS];
	logic signed [CW-1:0] vy_s  [CORDIC_STEPS];
	logic [TW-1:0]        acc_s [CORDIC_STEPS+1];

	logic signed [CW-1:0] nx   [CORDIC_STEPS];
	logic signed [CW-1:0] ny   [CORDIC_STEPS];
	logic [TW-1:0]        nacc [CORDIC_STEPS];

	always_comb begin
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (!vy_s[i][CW-1]) begin
				nx[i]   = vx_s[i] + (vy_s[i] >>> i);
				ny[i]   = vy_s[i] - (vx_s[i] >>> i);
				nacc[i] = acc_s[i] + hac_pkg::atan_val(i);
			end else begin
				nx[i]   = vx_s[i] - (vy_s[i] >>> i);
				ny[i]   = vy_s[i] + (vx_s[i] >>> i);
				nacc[i] = acc_s[i] - hac_pkg::atan_val(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_s[0]  <= vx;
			vy_s[0]  <= vy;
			acc_s[0] <= '0;
			for (int i = 0; i < CORDIC_STEPS - 1; i++) begin
				vx_s[i+1] <= nx[i];
				vy_s[i+1] <= ny[i];
			end
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				acc_s[i+1] <= nacc[i];
			end
		end
	end

	assign acc = acc_s[CORDIC_STEPS];

endmodule

@@ rtl/core/hac_back.sv @@
// ----------------------------------------------------------------------------
// hac_back
// Square roots, vector set-up, three CORDICs, clamping and rounding.
// ----------------------------------------------------------------------------
module hac_back #(
	parameter int ANGLE_BITS   = hac_pkg::ANGLE_BITS_DEF,
	parameter int CORDIC_STEPS = hac_pkg::CORDIC_STEPS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  hac_pkg::job_t job,
	input  logic          job_valid,
	output logic          job_ready,
	hac_ang_if.source     ang
);

	localparam int LS = hac_pkg::ROOT_W + 1;
	localparam int LT = CORDIC_STEPS + 1;
	localparam int D  = LS + LT + 1;
	localparam int SH = 32 - ANGLE_BITS;
	localparam logic [32:0] RND   = 33'((64'd1 << SH) >> 1);
	localparam logic [32:0] AMASK = 33'((64'd1 << ANGLE_BITS) - 64'd1);

	typedef struct packed {
		logic signed [hac_pkg::VEC_W-1:0]   vx_w;
		logic signed [hac_pkg::VEC_W-1:0]   vx_z;
		logic signed [hac_pkg::COORD_W-1:0] x;
		logic signed [hac_pkg::COORD_W-1:0] y;
		hac_pkg::case_t                     cc;
		logic                               ovr_half;
	} side_t;

	typedef struct packed {
		logic                              special;
		logic [hac_pkg::TURN_W-1:0]        spec_angle;
		logic [hac_pkg::TURN_W-1:0]        base;
		logic signed [hac_pkg::CV_W-1:0]   nx;
		logic signed [hac_pkg::CV_W-1:0]   ny;
	} prep_t;

	typedef struct packed {
		logic                       special;
		logic [hac_pkg::TURN_W-1:0] spec_angle;
		logic [hac_pkg::TURN_W-1:0] base;
	} vtail_t;

	typedef struct packed {
		vtail_t         pw;
		vtail_t         pz;
		vtail_t         az;
		hac_pkg::case_t cc;
		logic           ovr_half;
	} tail_t;

	// axis cases, half-plane fold and left normalisation to bit 30
	function automatic prep_t vec_prep(input logic signed [31:0] vx,
			input logic signed [31:0] vy);
		prep_t              p;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] mag;
		logic [31:0]        m;
		int                 sh;
		p  = '0;
		ax = vx;
		ay = vy;
		if (vy == '0) begin
			p.special    = 1'b1;
			p.spec_angle = vx[31] ? hac_pkg::TURN_HALF : '0;
		end else if (vx == '0) begin
			p.special    = 1'b1;
			p.spec_angle = vy[31] ? hac_pkg::TURN_3QUARTER : hac_pkg::TURN_QUARTER;
		end
		if (vx[31]) begin
			ax     = -vx;
			ay     = -vy;
			p.base = hac_pkg::TURN_HALF;
		end
		mag = ay[31] ? -ay : ay;
		m   = ax | mag;
		for (int j = 0; j < 5; j++) begin
			sh = 16 >> j;
			if ((m >> (31 - sh)) == 32'd0) begin
				m  = m << sh;
				ax = ax <<< sh;
				ay = ay <<< sh;
			end
		end
		p.nx = hac_pkg::CV_W'(ax);
		p.ny = hac_pkg::CV_W'(ay);
		return p;
	endfunction

	function automatic vtail_t to_tail(input prep_t p);
		vtail_t t;
		t.special    = p.special;
		t.spec_angle = p.spec_angle;
		t.base       = p.base;
		return t;
	endfunction

	function automatic logic [31:0] settle(input vtail_t t, input logic [31:0] acc);
		return t.special ? t.spec_angle : t.base + acc;
	endfunction

	// residue just past pi folds back to 0 or pi
	function automatic logic [31:0] clamp_polar(input logic [31:0] t);
		logic [31:0] r;
		r = t;
		if (t > hac_pkg::TURN_HALF) begin
			r = (t >= hac_pkg::TURN_3QUARTER) ? '0 : hac_pkg::TURN_HALF;
		end
		return r;
	endfunction

	function automatic logic [hac_pkg::ANGLE_W-1:0] to_out(input logic [31:0] t);
		logic [32:0] s;
		s = (({1'b0, t} + RND) >> SH) & AMASK;
		return s[hac_pkg::ANGLE_W-1:0];
	endfunction

	logic        en;
	logic        take;
	logic [D-1:0] vld_q;
	side_t       side_in;
	side_t       side_q [LS];
	side_t       side_o;
	tail_t       tail_in;
	tail_t       tail_q [LT];
	tail_t       tail_o;
	logic [hac_pkg::ROOT_W-1:0] root_w;
	logic [hac_pkg::ROOT_W-1:0] root_r;
	prep_t       pp_w;
	prep_t       pp_z;
	prep_t       pp_a;
	logic [31:0] acc_w;
	logic [31:0] acc_z;
	logic [31:0] acc_a;
	logic [31:0] t_w;
	logic [31:0] t_z;
	logic [31:0] t_a;

	// whole pipe advances unless a finished result is held
	assign en        = !(vld_q[D-1] && !ang.ready);
	assign job_ready = en;
	assign take      = job_valid && en;
	assign ang.valid = vld_q[D-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[D-2:0], take};
		end
	end

	always_comb begin
		side_in.vx_w     = job.vx_w;
		side_in.vx_z     = job.vx_z;
		side_in.x        = job.x;
		side_in.y        = job.y;
		side_in.cc       = job.cc;
		side_in.ovr_half = job.ovr_half;
	end

	hac_sqrt_pipe u_sqrt_w (
		.clk  (clk),
		.en   (en),
		.rad  (job.rad_w),
		.root (root_w)
	);

	hac_sqrt_pipe u_sqrt_r (
		.clk  (clk),
		.en   (en),
		.rad  (job.rad_r),
		.root (root_r)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_in;
			for (int j = 1; j < LS; j++) begin
				side_q[j] <= side_q[j-1];
			end
			tail_q[0] <= tail_in;
			for (int j = 1; j < LT; j++) begin
				tail_q[j] <= tail_q[j-1];
			end
		end
	end

	assign side_o = side_q[LS-1];
	assign tail_o = tail_q[LT-1];

	always_comb begin
		pp_w = vec_prep(side_o.vx_w, {1'b0, root_w});
		pp_z = vec_prep(side_o.vx_z, {1'b0, root_r});
		pp_a = vec_prep(32'(side_o.y), 32'(side_o.x));
		tail_in.pw       = to_tail(pp_w);
		tail_in.pz       = to_tail(pp_z);
		tail_in.az       = to_tail(pp_a);
		tail_in.cc       = side_o.cc;
		tail_in.ovr_half = side_o.ovr_half;
	end

	hac_cordic_pipe #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_w (
		.clk (clk),
		.en  (en),
		.vx  (pp_w.nx),
		.vy  (pp_w.ny),
		.acc (acc_w)
	);

	hac_cordic_pipe #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_z (
		.clk (clk),
		.en  (en),
		.vx  (pp_z.nx),
		.vy  (pp_z.ny),
		.acc (acc_z)
	);

	hac_cordic_pipe #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic_a (
		.clk (clk),
		.en  (en),
		.vx  (pp_a.nx),
		.vy  (pp_a.ny),
		.acc (acc_a)
	);

	always_comb begin
		t_w = clamp_polar(settle(tail_o.pw, acc_w));
		t_z = clamp_polar(settle(tail_o.pz, acc_z));
		t_a = settle(tail_o.az, acc_a);
		if (tail_o.cc != hac_pkg::CASE_GENERAL) begin
			t_z = tail_o.ovr_half ? hac_pkg::TURN_HALF : '0;
			t_a = tail_o.ovr_half ? hac_pkg::TURN_HALF : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang.polar_w   <= to_out(t_w);
			ang.polar_z   <= to_out(t_z);
			ang.azimuth   <= to_out(t_a);
			ang.case_code <= tail_o.cc;
		end
	end

	a_degen_equal: assert property (@(posedge clk) disable iff (!arst_n)
		ang.valid && ang.case_code != hac_pkg::CASE_GENERAL |->
			ang.polar_z == ang.azimuth)
		else $error("degenerate point with differing polar_z and azimuth");

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline moved while stalled");

endmodule

@@ rtl/core/hyperspherical_angle_converter.sv @@
// ----------------------------------------------------------------------------
// hyperspherical_angle_converter
// Converts a point (x, y, z, w) of the 4-D unit sphere, signed with
// COORD_FRAC_BITS fraction bits, into polar_w = acos(w), polar_z =
// atan2(sqrt(x^2+y^2), z) and azimuth = atan2(x, y), as fractions of a turn
// rounded to ANGLE_BITS bits (a full turn is 2^ANGLE_BITS, wrapped into the
// 16-bit fields), plus a case code for points on the z axis or at the xyz
// origin. One point is taken every clock cycle while the queue has room; the
// queue fills only while the sink holds back results. A point passes the
// queue, the bit-per-stage square roots, the stage-per-rotation CORDICs and
// the output register. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module hyperspherical_angle_converter #(
	parameter int COORD_FRAC_BITS = hac_pkg::COORD_FRAC_BITS_DEF,
	parameter int ANGLE_BITS      = hac_pkg::ANGLE_BITS_DEF,
	parameter int CORDIC_STEPS    = hac_pkg::CORDIC_STEPS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	hac_pt_if.sink    pt,
	hac_ang_if.source ang
);

	// front -> queue
	hac_pkg::job_t f_job;
	logic          f_valid;
	logic          f_ready;
	// queue -> back
	hac_pkg::job_t q_job;
	logic          q_valid;
	logic          q_ready;

	// classify, saturate w, build radicands
	hac_front #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_front (
		.pt        (pt),
		.job       (f_job),
		.job_valid (f_valid),
		.job_ready (f_ready)
	);

	// lets front keep accepting up to QUEUE_DEPTH points while the back is held by the sink
	hac_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_data  (f_job),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.rd_data  (q_job),
		.rd_valid (q_valid),
		.rd_ready (q_ready)
	);

	// roots, CORDICs and output register
	hac_back #(
		.ANGLE_BITS   (ANGLE_BITS),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (q_job),
		.job_valid (q_valid),
		.job_ready (q_ready),
		.ang       (ang)
	);

endmodule
